/* rtl/core/fsc_pkg.sv */
package fsc_pkg;

   localparam int MAX_PLANES   = 8;
   localparam int PLANE_WORDS  = MAX_PLANES * 4;
   localparam int MAT_WORDS    = 16;
   localparam int BUILD_PLANES = 6;

   localparam int PL_AW  = $clog2(PLANE_WORDS);
   localparam int MAT_AW = $clog2(MAT_WORDS);
   localparam int PIDX_W = $clog2(MAX_PLANES);
   localparam int CNT_W  = $clog2(MAX_PLANES + 1);

   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;
   localparam int DVD_W  = 48;

   localparam logic [2:0] FN_LOAD_MATRIX = 3'd0;
   localparam logic [2:0] FN_LOAD_PLANE  = 3'd1;
   localparam logic [2:0] FN_BUILD       = 3'd2;
   localparam logic [2:0] FN_COMMIT      = 3'd3;
   localparam logic [2:0] FN_TEST        = 3'd4;

   localparam logic [1:0] V_SETUP   = 2'd0;
   localparam logic [1:0] V_OUTSIDE = 2'd1;
   localparam logic [1:0] V_INSIDE  = 2'd2;
   localparam logic [1:0] V_CROSS   = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic [4:0]         slot;
      logic signed [31:0] value;
      logic [3:0]         plane_total;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       degenerate;
   } rsp_type;

endpackage

/* rtl/core/frustum_sphere_classifier_core.sv */
// channel   | ports                      | direction | transfer when
// ----------+----------------------------+-----------+------------------------
// request   | start, busy, req_data      | in        | start && !busy
// result    | rsp_strobe, rsp_data       | out       | rsp_strobe (one cycle)
// csr       | csr_we, csr_wdata (margin) | in        | csr_we
//
// Loads and unused functions answer in the cycle after the transfer, busy stays low.
// Sphere test: one plane word per cycle through the single read port of the plane
// memory; with no planes the answer comes in the cycle after the transfer.
// Build and commit: each plane with a nonzero normal goes through the bit-serial
// square root (32 steps) and the bit-serial divide (48 steps per component).
// Synchronous reset clears control state, plane count and margin (to 1); the
// memories hold no reset value. The result side cannot stall.
module frustum_sphere_classifier_core import fsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_BUILD, ST_NRD, ST_NSQ, ST_NSQRT, ST_NDIV, ST_NDIVW, ST_TEST
   } state_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = s[63:0];
      end
   endfunction

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      if (v[33:31] != 3'b000 && v[33:31] != 3'b111) begin
         sat34 = v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         sat34 = v[31:0];
      end
   endfunction

   state_type          state_ff, state_in;
   logic [15:0]        margin_ff, margin_in;
   logic [CNT_W-1:0]   plane_count_ff, plane_count_in;
   logic [CNT_W-1:0]   plane_ff, plane_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [1:0]         sub_ff, sub_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] comp_ff [4];
   logic signed [31:0] comp_in [4];
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        sum_ff, sum_in;
   logic [ROOT_W-1:0]  len_ff, len_in;
   logic               degen_ff, degen_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [63:0] thr_ff, thr_in, nthr_ff, nthr_in;
   logic               issue_ff, issue_in;
   logic               rv_ff, rv_in;
   logic [1:0]         rsub_ff, rsub_in;
   logic               pv_ff, pv_in;
   logic               pfirst_ff, pfirst_in, plast_ff, plast_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               av_ff, av_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               outside_ff, outside_in, allin_ff, allin_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               mat_we;
   logic [MAT_AW-1:0]  mat_waddr, mat_raddr;
   logic [31:0]        mat_wdata, mat_rdata;
   logic               pl_we;
   logic [PL_AW-1:0]   pl_waddr, pl_raddr;
   logic [31:0]        pl_wdata, pl_rdata;

   logic               sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]  sqrt_root;
   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_num, div_quo;

   logic signed [31:0] mul_a, mul_b, sq_op, cur_c;
   logic signed [63:0] mul_p, sq_p;
   logic signed [33:0] bsum;
   logic [1:0]         bcol;
   logic               bplus;
   logic [31:0]        cmag, rsum;
   logic [CNT_W-1:0]   tot, next_plane;
   logic               qbig;
   logic [31:0]        qres;

   assign mul_a = $signed(pl_rdata);
   assign mul_p = mul_a * mul_b;
   assign sq_p  = sq_op * sq_op;

   always_comb begin
      state_in       = state_ff;
      margin_in      = margin_ff;
      plane_count_in = plane_count_ff;
      plane_in       = plane_ff;
      total_in       = total_ff;
      sub_in         = sub_ff;
      cnt_in         = cnt_ff;
      a_in           = a_ff;
      comp_in        = comp_ff;
      sq_in          = sq_ff;
      sum_in         = sum_ff;
      len_in         = len_ff;
      degen_in       = degen_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cz_in          = cz_ff;
      thr_in         = thr_ff;
      nthr_in        = nthr_ff;
      issue_in       = issue_ff;
      outside_in     = outside_ff;
      allin_in       = allin_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      mat_we         = 1'b0;
      mat_waddr      = req_data.slot[MAT_AW-1:0];
      mat_wdata      = req_data.value;
      mat_raddr      = '0;
      pl_we          = 1'b0;
      pl_waddr       = req_data.slot[PL_AW-1:0];
      pl_wdata       = req_data.value;
      pl_raddr       = '0;
      sqrt_start     = 1'b0;
      div_start      = 1'b0;
      sq_op          = comp_ff[cnt_ff[1:0]];
      cur_c          = comp_ff[cnt_ff[1:0]];
      cmag           = cur_c[31] ? 32'(-cur_c) : 32'(cur_c);
      div_num        = {cmag, 16'h0} + DVD_W'(len_ff >> 1);
      qbig           = div_quo >= DVD_W'(32'h8000_0000);
      if (cur_c[31]) begin
         qres = qbig ? 32'h8000_0000 : 32'(-div_quo[31:0]);
      end else begin
         qres = qbig ? 32'h7FFF_FFFF : div_quo[31:0];
      end
      next_plane     = plane_ff + CNT_W'(1);
      bcol           = 2'(plane_ff >> 1);
      bplus          = plane_ff == CNT_W'(0) || plane_ff == CNT_W'(3) ||
                       plane_ff == CNT_W'(5);
      bsum           = bplus ? -(34'(a_ff) + 34'($signed(mat_rdata)))
                             : -(34'(a_ff) - 34'($signed(mat_rdata)));
      rsum           = 32'(req_data.radius) + 32'(margin_in);
      tot            = ({1'b0, req_data.plane_total} > 5'(MAX_PLANES)) ?
                       CNT_W'(MAX_PLANES) : CNT_W'(req_data.plane_total);

      if (csr_we) begin
         margin_in = csr_wdata;
      end

      // distance pipeline: read, multiply, accumulate, compare
      rv_in     = 1'b0;
      rsub_in   = sub_ff;
      pv_in     = rv_ff;
      pfirst_in = rsub_ff == 2'd0;
      plast_in  = rsub_ff == 2'd3;
      av_in     = pv_ff & plast_ff;
      unique case (rsub_ff)
         2'd2:    mul_b = cy_ff;
         2'd3:    mul_b = cz_ff;
         default: mul_b = cx_ff;
      endcase
      prod_in = (rsub_ff == 2'd0) ? {{16{pl_rdata[31]}}, pl_rdata, 16'h0} : mul_p;
      acc_in  = acc_ff;
      if (pv_ff) begin
         acc_in = pfirst_ff ? prod_ff : sat_add64(acc_ff, prod_ff);
      end
      if (av_ff) begin
         if (acc_ff > thr_ff) begin
            outside_in = 1'b1;
         end
         if (!(acc_ff < nthr_ff)) begin
            allin_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in.verdict    = V_SETUP;
               rsp_data_in.degenerate = 1'b0;
               priority case (req_data.func)
                  FN_LOAD_MATRIX: begin
                     mat_we        = int'(req_data.slot) < MAT_WORDS;
                     rsp_strobe_in = 1'b1;
                  end
                  FN_LOAD_PLANE: begin
                     pl_we         = int'(req_data.slot) < PLANE_WORDS;
                     rsp_strobe_in = 1'b1;
                  end
                  FN_BUILD: begin
                     plane_in = '0;
                     sub_in   = '0;
                     cnt_in   = '0;
                     degen_in = 1'b0;
                     state_in = ST_BUILD;
                  end
                  FN_COMMIT: begin
                     plane_count_in = tot;
                     total_in       = tot;
                     plane_in       = '0;
                     cnt_in         = '0;
                     degen_in       = 1'b0;
                     if (tot == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_NRD;
                     end
                  end
                  FN_TEST: begin
                     cx_in      = req_data.center_x;
                     cy_in      = req_data.center_y;
                     cz_in      = req_data.center_z;
                     thr_in     = $signed({16'h0, rsum, 16'h0});
                     nthr_in    = -$signed({16'h0, rsum, 16'h0});
                     outside_in = 1'b0;
                     allin_in   = 1'b1;
                     plane_in   = '0;
                     sub_in     = '0;
                     if (plane_count_ff == '0) begin
                        rsp_data_in.verdict = V_INSIDE;
                        rsp_strobe_in       = 1'b1;
                     end else begin
                        issue_in = 1'b1;
                        state_in = ST_TEST;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_BUILD: begin
            priority case (cnt_ff)
               3'd0: begin
                  mat_raddr = {sub_ff, 2'd3};
                  cnt_in    = 3'd1;
               end
               3'd1: begin
                  mat_raddr = {sub_ff, bcol};
                  a_in      = $signed(mat_rdata);
                  cnt_in    = 3'd2;
               end
               default: begin
                  pl_we    = 1'b1;
                  pl_waddr = {plane_ff[PIDX_W-1:0], sub_ff};
                  pl_wdata = sat34(bsum);
                  cnt_in   = 3'd0;
                  sub_in   = sub_ff + 2'd1;
                  if (sub_ff == 2'd3) begin
                     plane_in = next_plane;
                     if (plane_ff == CNT_W'(BUILD_PLANES - 1)) begin
                        plane_in       = '0;
                        total_in       = CNT_W'(BUILD_PLANES);
                        plane_count_in = CNT_W'(BUILD_PLANES);
                        state_in       = ST_NRD;
                     end
                  end
               end
            endcase
         end
         ST_NRD: begin
            if (cnt_ff != 3'd4) begin
               pl_raddr = {plane_ff[PIDX_W-1:0], cnt_ff[1:0]};
            end
            for (int e = 0; e < 4; e++) begin
               if (cnt_ff == 3'(e + 1)) begin
                  comp_in[e] = $signed(pl_rdata);
               end
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = ST_NSQ;
            end
         end
         ST_NSQ: begin
            sq_in  = sq_p;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               sum_in = sq_ff;
            end else if (cnt_ff == 3'd2 || cnt_ff == 3'd3) begin
               sum_in = sum_ff + sq_ff;
            end else if (cnt_ff == 3'd4) begin
               cnt_in = '0;
               if (comp_ff[0] == 0 && comp_ff[1] == 0 && comp_ff[2] == 0) begin
                  degen_in = 1'b1;
                  plane_in = next_plane;
                  state_in = ST_NRD;
                  if (next_plane == total_ff) begin
                     rsp_data_in.verdict    = V_SETUP;
                     rsp_data_in.degenerate = degen_in;
                     rsp_strobe_in          = 1'b1;
                     state_in               = ST_IDLE;
                  end
               end else begin
                  sqrt_start = 1'b1;
                  state_in   = ST_NSQRT;
               end
            end
         end
         ST_NSQRT: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               cnt_in   = '0;
               state_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            div_start = 1'b1;
            state_in  = ST_NDIVW;
         end
         ST_NDIVW: begin
            if (div_done) begin
               pl_we    = 1'b1;
               pl_waddr = {plane_ff[PIDX_W-1:0], cnt_ff[1:0]};
               pl_wdata = qres;
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_NDIV;
               if (cnt_ff == 3'd3) begin
                  cnt_in   = '0;
                  plane_in = next_plane;
                  state_in = ST_NRD;
                  if (next_plane == total_ff) begin
                     rsp_data_in.verdict    = V_SETUP;
                     rsp_data_in.degenerate = degen_ff;
                     rsp_strobe_in          = 1'b1;
                     state_in               = ST_IDLE;
                  end
               end
            end
         end
         ST_TEST: begin
            if (issue_ff) begin
               pl_raddr = {plane_ff[PIDX_W-1:0], sub_ff - 2'd1};
               rv_in    = 1'b1;
               sub_in   = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  plane_in = next_plane;
                  if (next_plane == plane_count_ff) begin
                     issue_in = 1'b0;
                  end
               end
            end else if (!rv_ff && !pv_ff && !av_ff) begin
               rsp_data_in.verdict    = outside_ff ? V_OUTSIDE :
                                        (allin_ff ? V_INSIDE : V_CROSS);
               rsp_data_in.degenerate = 1'b0;
               rsp_strobe_in          = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         margin_ff      <= 16'd1;
         plane_count_ff <= '0;
         issue_ff       <= 1'b0;
         rv_ff          <= 1'b0;
         pv_ff          <= 1'b0;
         av_ff          <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         margin_ff      <= margin_in;
         plane_count_ff <= plane_count_in;
         issue_ff       <= issue_in;
         rv_ff          <= rv_in;
         pv_ff          <= pv_in;
         av_ff          <= av_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      plane_ff    <= plane_in;
      total_ff    <= total_in;
      sub_ff      <= sub_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
      comp_ff     <= comp_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      degen_ff    <= degen_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      thr_ff      <= thr_in;
      nthr_ff     <= nthr_in;
      rsub_ff     <= rsub_in;
      pfirst_ff   <= pfirst_in;
      plast_ff    <= plast_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      outside_ff  <= outside_in;
      allin_ff    <= allin_in;
      rsp_data_ff <= rsp_data_in;
   end

   fsc_ram #(.WIDTH(32), .DEPTH(MAT_WORDS)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   fsc_ram #(.WIDTH(32), .DEPTH(PLANE_WORDS)) u_plane_ram (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_waddr),
      .wr_data (pl_wdata),
      .rd_addr (pl_raddr),
      .rd_data (pl_rdata)
   );

   fsc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_load_answers_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func == FN_LOAD_MATRIX ||
                          req_data.func == FN_LOAD_PLANE)) |=> rsp_strobe)
      else $error("load transfer without result in the next cycle");

   a_degen_only_setup: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.degenerate) |-> rsp_data.verdict == V_SETUP)
      else $error("degenerate flag on a sphere verdict");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      plane_count_ff <= CNT_W'(MAX_PLANES))
      else $error("plane count beyond store");

endmodule

/* rtl/core/fsc_ram.sv */
module fsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fsc_isqrt.sv */
module fsc_isqrt import fsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [RAD_W-1:0]  n_ff, n_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, n_ff[RAD_W-1:RAD_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         n_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         n_in = {n_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (ROOT_W+1)'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/core/fsc_divider.sv */
module fsc_divider import fsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [ROOT_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [ROOT_W-1:0] dsr_ff, dsr_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [ROOT_W:0]   rem_sh;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = ROOT_W'(rem_sh - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[ROOT_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

/* tb/sv/tb.sv */
module tb;
   import fsc_pkg::*;

   localparam int LIMIT_CYCLES = 4_000_000;
   localparam logic [2:0] FN_SPARE = 3'd5;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   frustum_sphere_classifier_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   req_type pending_cmds[$];
   rsp_type verdict_queue[$];
   int      errors = 0;
   int      idle_pct = 0;
   int      cycle_count = 0;
   int      n_items = 0;
   int      n_tests = 0;
   int      n_setups = 0;

   // generator view of which store entries hold data
   bit [15:0] mat_written;
   bit [31:0] plane_written;

   // predictor state
   int signed       mat_mirror[16];
   int signed       plane_mirror[PLANE_WORDS];
   int unsigned     active_planes;
   longint unsigned margin_q;

   function automatic int signed clip32(longint signed v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint signed add_clip64(longint signed a, longint signed b);
      longint signed s;
      s = a + b;
      if (a >= 0 && b > 0 && s < 0) return 64'sh7fffffffffffffff;
      if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
      return s;
   endfunction

   function automatic bit normalize_plane(int k);
      longint unsigned sum, len, n, root, bitv, mag, q;
      longint signed   c;
      if (plane_mirror[4*k] == 0 && plane_mirror[4*k+1] == 0 && plane_mirror[4*k+2] == 0)
         return 1'b1;
      sum = 0;
      for (int j = 0; j < 3; j++) begin
         c = plane_mirror[4*k+j];
         sum += longint'(c * c);
      end
      n = sum;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      len = root;
      for (int j = 0; j < 4; j++) begin
         c = plane_mirror[4*k+j];
         mag = (c < 0) ? longint'(-c) : longint'(c);
         q = ((mag << 16) + len / 2) / len;
         if (q > 64'h80000000) q = 64'h80000000;
         plane_mirror[4*k+j] = clip32((c < 0) ? -longint'(q) : longint'(q));
      end
      return 1'b0;
   endfunction

   function automatic rsp_type classify(req_type it);
      rsp_type         r;
      int unsigned     tot;
      longint signed   a, b, d, thr;
      bit              outside, all_in;
      r = '0;
      r.verdict = V_SETUP;
      case (it.func)
         FN_LOAD_MATRIX: if (it.slot < MAT_WORDS) mat_mirror[it.slot] = it.value;
         FN_LOAD_PLANE: if (it.slot < PLANE_WORDS) plane_mirror[it.slot] = it.value;
         FN_BUILD: begin
            for (int i = 0; i < BUILD_PLANES; i++) begin
               for (int j = 0; j < 4; j++) begin
                  a = mat_mirror[j*4+3];
                  b = mat_mirror[j*4+i/2];
                  plane_mirror[i*4+j] = (i == 0 || i == 3 || i == 5) ? clip32(-(a + b))
                                                                    : clip32(-(a - b));
               end
            end
            active_planes = BUILD_PLANES;
            for (int i = 0; i < BUILD_PLANES; i++)
               if (normalize_plane(i)) r.degenerate = 1'b1;
         end
         FN_COMMIT: begin
            tot = (it.plane_total > MAX_PLANES) ? MAX_PLANES : it.plane_total;
            active_planes = tot;
            for (int i = 0; i < tot; i++)
               if (normalize_plane(i)) r.degenerate = 1'b1;
         end
         FN_TEST: begin
            thr = (longint'(it.radius) + longint'(margin_q)) * 65536;
            outside = 1'b0;
            all_in = 1'b1;
            for (int i = 0; i < active_planes; i++) begin
               d = longint'(plane_mirror[4*i+3]) * 65536;
               d = add_clip64(d, longint'(plane_mirror[4*i]) * longint'(it.center_x));
               d = add_clip64(d, longint'(plane_mirror[4*i+1]) * longint'(it.center_y));
               d = add_clip64(d, longint'(plane_mirror[4*i+2]) * longint'(it.center_z));
               if (d > thr) begin
                  outside = 1'b1;
                  break;
               end
               if (!(d < -thr)) all_in = 1'b0;
            end
            r.verdict = outside ? V_OUTSIDE : (all_in ? V_INSIDE : V_CROSS);
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      bit accepted;
      accepted = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (accepted) begin
            verdict_queue.push_back(classify(req_data));
            if (req_data.func == FN_TEST) n_tests++;
            else n_setups++;
         end
         if (!start || accepted) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_data <= pending_cmds.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_data.verdict !== want.verdict) begin
               $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                        rsp_data.verdict);
               errors++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %0d actual %0d", $time,
                        want.degenerate, rsp_data.degenerate);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int ready_planes();
      int k;
      k = 0;
      while (k < MAX_PLANES && plane_written[4*k +: 4] == 4'hf) k++;
      return k;
   endfunction

   function automatic int signed rnd_val();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         2: return int'($urandom_range(32'h80000)) - 32'sh40000;
         default: return int'($urandom_range(32'h30000)) - 32'sh18000;
      endcase
   endfunction

   task automatic push_cmd(req_type it);
      if (it.func == FN_LOAD_MATRIX && it.slot < MAT_WORDS) mat_written[it.slot] = 1'b1;
      if (it.func == FN_LOAD_PLANE) plane_written[it.slot] = 1'b1;
      pending_cmds.push_back(it);
      n_items++;
   endtask

   task automatic push_load(logic [2:0] fn, int slot, int signed v);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.func = fn;
      it.slot = 5'(slot);
      it.value = v;
      push_cmd(it);
   endtask

   task automatic push_test(int signed cx, int signed cy, int signed cz, int rad);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.func = FN_TEST;
      it.center_x = cx;
      it.center_y = cy;
      it.center_z = cz;
      it.radius = 31'(rad);
      push_cmd(it);
   endtask

   task automatic push_ctl(logic [2:0] fn, int tot);
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      it.func = fn;
      it.plane_total = 4'(tot);
      push_cmd(it);
   endtask

   task automatic push_rnd_test();
      int signed s;
      if ($urandom_range(2) == 0)
         push_test($urandom, $urandom, $urandom, $urandom_range(1) ? $urandom : 0);
      else begin
         s = int'($urandom_range(32'h60000)) - 32'sh30000;
         push_test(s, int'($urandom_range(32'h60000)) - 32'sh30000,
                   int'($urandom_range(32'h60000)) - 32'sh30000, $urandom_range(32'h20000));
      end
   endtask

   // copies column 3 into column 0 so the left/right pair can come out flat
   function automatic int signed mat_mirror_gen(int r);
      req_type it;
      for (int i = pending_cmds.size() - 1; i >= 0; i--) begin
         it = pending_cmds[i];
         if (it.func == FN_LOAD_MATRIX && it.slot == r*4+3) return it.value;
      end
      return 0;
   endfunction

   task automatic random_phase(int n);
      int stop_at, np, tot;
      bit flat;
      stop_at = n_items + n;
      while (n_items < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               flat = ($urandom_range(5) == 0);
               for (int s = 0; s < MAT_WORDS; s++)
                  push_load(FN_LOAD_MATRIX, s, rnd_val());
               if (flat)
                  for (int r = 0; r < 4; r++) push_load(FN_LOAD_MATRIX, r*4, mat_mirror_gen(r));
               push_ctl(FN_BUILD, $urandom_range(15));
               repeat ($urandom_range(8, 25)) push_rnd_test();
            end
            4, 5, 6: begin
               np = $urandom_range(MAX_PLANES);
               for (int k = 0; k < np; k++) begin
                  flat = ($urandom_range(7) == 0);
                  for (int j = 0; j < 4; j++)
                     push_load(FN_LOAD_PLANE, 4*k+j, (flat && j < 3) ? 0 : rnd_val());
               end
               tot = (np == MAX_PLANES && $urandom_range(1)) ? $urandom_range(MAX_PLANES, 15)
                                                             : np;
               push_ctl(FN_COMMIT, tot);
               repeat ($urandom_range(8, 25)) push_rnd_test();
            end
            default: begin
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(6))
                     0: push_load(FN_LOAD_MATRIX, $urandom_range(31), $urandom);
                     1: push_load(FN_LOAD_PLANE, $urandom_range(31), rnd_val());
                     2: if (mat_written == 16'hffff) push_ctl(FN_BUILD, $urandom_range(15));
                     3: push_ctl(FN_COMMIT, (ready_planes() == MAX_PLANES)
                                    ? $urandom_range(15) : $urandom_range(ready_planes()));
                     4: push_ctl(3'(FN_SPARE + $urandom_range(2)), $urandom_range(15));
                     default: push_rnd_test();
                  endcase
               end
            end
         endcase
      end
   endtask

   task automatic settle_and_set_margin(logic [15:0] m);
      while (pending_cmds.size() > 0 || start || verdict_queue.size() > 0) @(posedge clock);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      margin_q = m;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mat_written = '0;
      plane_written = '0;
      active_planes = 0;
      margin_q = 1;
      foreach (mat_mirror[i]) mat_mirror[i] = 0;
      foreach (plane_mirror[i]) plane_mirror[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty plane set, unused codes, ignored slots, flat normals
      push_test(32'sh7fffffff, 32'sh80000000, 0, 31'h7fffffff);
      push_test(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
      push_ctl(FN_SPARE, 15);
      push_ctl(3'd6, 0);
      push_ctl(3'd7, 8);
      push_load(FN_LOAD_MATRIX, 16, 32'sh7fffffff);
      push_load(FN_LOAD_MATRIX, 31, 32'sh80000000);
      push_ctl(FN_COMMIT, 0);
      push_load(FN_LOAD_PLANE, 0, 0);
      push_load(FN_LOAD_PLANE, 1, 0);
      push_load(FN_LOAD_PLANE, 2, 0);
      push_load(FN_LOAD_PLANE, 3, 32'sh50000);
      push_ctl(FN_COMMIT, 1);
      push_test(0, 0, 0, 0);
      push_test(0, 0, 0, 31'h100000);
      push_load(FN_LOAD_PLANE, 4, 32'sh7fffffff);
      push_load(FN_LOAD_PLANE, 5, 32'sh80000000);
      push_load(FN_LOAD_PLANE, 6, 32'sh7fffffff);
      push_load(FN_LOAD_PLANE, 7, 32'sh80000000);
      push_ctl(FN_COMMIT, 2);
      push_test(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
      push_test(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
      push_load(FN_LOAD_PLANE, 7, 32'sh7fffffff);
      push_test(0, 0, 0, 0);

      settle_and_set_margin(16'h0000);
      idle_pct = 30;
      random_phase(430);
      settle_and_set_margin(16'hffff);
      idle_pct = 88;
      random_phase(430);
      settle_and_set_margin(16'($urandom));
      idle_pct = 0;
      random_phase(430);

      while (pending_cmds.size() > 0 || start || verdict_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Run covered %0d items: %0d sphere tests, %0d setup or other commands,",
               n_items, n_tests, n_setups);
      $display("over four margin settings including 0 and 65535.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
